// File: rtl/bts_pkg.sv
// Shared constants, types and register codes for the binary thinning sub-pass unit.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
package bts_pkg;

    // Deepest line that the line buffers can hold.
    localparam int MAX_WIDTH = 2048;
    // Widest row that is ever used; the column counter never passes it.
    localparam int WIDTH_CAP = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
    localparam int ADDR_W    = (WIDTH_CAP > 1) ? $clog2(WIDTH_CAP) : 1;

    localparam int DIM_W     = 12;
    localparam int POS_W     = 11;
    localparam int CFG_IDX_W = 2;

    typedef logic [DIM_W-1:0]     dim_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Configuration register indexes.
    localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
    localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;
    localparam cfg_idx_t REG_PASS_SELECT  = 2'd2;

    localparam dim_t WIDTH_RESET  = 12'd640;
    localparam dim_t HEIGHT_RESET = 12'd480;
    localparam dim_t WIDTH_MIN    = 12'd3;
    localparam dim_t WIDTH_MAX    = DIM_W'(WIDTH_CAP);
    localparam dim_t HEIGHT_MIN   = 12'd3;
    localparam dim_t HEIGHT_MAX   = 12'd2048;
    localparam dim_t ROW_LIMIT    = 12'd4095;

    // Bounds on the count of set neighbors for a removable pixel.
    localparam logic [3:0] NB_COUNT_MIN = 4'd2;
    localparam logic [3:0] NB_COUNT_MAX = 4'd6;

    // Operation codes of an input request.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Sub-pass codes.
    localparam logic PASS_FIRST  = 1'b0;
    localparam logic PASS_SECOND = 1'b1;

    // One accepted request on its way from the scan counters to the window.
    typedef struct packed {
        logic  px;
        logic  fs;
        logic  emit;
        logic  border;
        logic  frame_end;
        pos_t  row;
        pos_t  col;
        addr_t addr;
    } item_t;

endpackage

// File: rtl/binary_thinning_subpass_unit.sv
// Top level of the binary thinning sub-pass unit: configuration registers and pipeline control.
// Depends on bts_pkg, bts_scan_ctrl, bts_line_buffer and bts_window_eval.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------------------------
//   input   | in        | in_valid / in_stall | operation, pixel_in, frame_start
//   output  | out       | out_valid/out_stall | pixel_out, out_row, out_col, frame_end
//   config  | in        | cfg_write_en        | cfg_index, cfg_data
//
// One request is accepted every cycle unless in_stall is high. The line buffer read is
// registered together with the accepted request; the window update and the thinning decision
// then load the result register. The result for a pixel appears width+1 requests after it
// entered. Reset clears the counters, the window and all valid flags; the line buffers
// are not cleared. The input is stalled only while a result waits in the output
// register and the output side is stalling, so the whole pipeline freezes together.
module binary_thinning_subpass_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                operation,
    input  logic                pixel_in,
    input  logic                frame_start,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                pixel_out,
    output logic [10:0]         out_row,
    output logic [10:0]         out_col,
    output logic                frame_end,
    input  logic                cfg_write_en,
    input  bts_pkg::cfg_idx_t   cfg_index,
    input  logic [11:0]         cfg_data
);

    bts_pkg::dim_t  width_reg;
    bts_pkg::dim_t  height_reg;
    logic           pass_reg;
    bts_pkg::dim_t  eff_width;
    bts_pkg::dim_t  eff_height;

    logic           advance;
    logic           accept;
    bts_pkg::addr_t rd_addr;
    logic           s1_valid;
    bts_pkg::item_t s1_item;
    logic [1:0]     line_bits;

    // Configuration writes land at once; values outside the legal range are clamped
    // where they are used, not where they are stored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bts_pkg::WIDTH_RESET;
            height_reg <= bts_pkg::HEIGHT_RESET;
            pass_reg   <= bts_pkg::PASS_FIRST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                bts_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                bts_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                bts_pkg::REG_PASS_SELECT:  pass_reg   <= cfg_data[0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < bts_pkg::WIDTH_MIN)
            eff_width = bts_pkg::WIDTH_MIN;
        else if (width_reg > bts_pkg::WIDTH_MAX)
            eff_width = bts_pkg::WIDTH_MAX;
        else
            eff_width = width_reg;

        if (height_reg < bts_pkg::HEIGHT_MIN)
            eff_height = bts_pkg::HEIGHT_MIN;
        else if (height_reg > bts_pkg::HEIGHT_MAX)
            eff_height = bts_pkg::HEIGHT_MAX;
        else
            eff_height = height_reg;
    end

    // The pipeline moves whenever the result register is empty or being taken.
    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    bts_scan_ctrl u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .advance     (advance),
        .operation   (operation),
        .pixel_in    (pixel_in),
        .frame_start (frame_start),
        .eff_width   (eff_width),
        .eff_height  (eff_height),
        .rd_addr     (rd_addr),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item)
    );

    // The upper line takes the old middle bit; the middle line takes the new pixel.
    bts_line_buffer u_lines (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .wr_en   (advance && s1_valid),
        .wr_addr (s1_item.addr),
        .wr_data ({line_bits[0], s1_item.px}),
        .rd_data (line_bits)
    );

    bts_window_eval u_eval (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .s1_valid    (s1_valid),
        .s1_item     (s1_item),
        .top_bit     (line_bits[1]),
        .mid_bit     (line_bits[0]),
        .pass_select (pass_reg),
        .out_valid   (out_valid),
        .pixel_out   (pixel_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .frame_end   (frame_end)
    );

    // Input stalls only happen behind a held result.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result waiting");

endmodule

// File: rtl/bts_scan_ctrl.sv
// Raster scan counters and the stage register that holds one accepted request.
// Depends on bts_pkg for widths, limits and the item_t struct.
module bts_scan_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic            advance,
    input  logic            operation,
    input  logic            pixel_in,
    input  logic            frame_start,
    input  bts_pkg::dim_t   eff_width,
    input  bts_pkg::dim_t   eff_height,
    output bts_pkg::addr_t  rd_addr,
    output logic            s1_valid,
    output bts_pkg::item_t  s1_item
);

    bts_pkg::pos_t  col_reg, col_next;
    bts_pkg::dim_t  row_reg, row_next;
    bts_pkg::dim_t  fill_reg, fill_next;
    logic           s1_valid_reg, s1_valid_next;
    bts_pkg::item_t s1_item_reg;
    bts_pkg::item_t item_next;

    bts_pkg::pos_t  col_cur;
    bts_pkg::dim_t  row_cur;
    bts_pkg::dim_t  fill_cur;
    bts_pkg::dim_t  out_row;
    bts_pkg::dim_t  out_col;
    logic           col_nz;
    logic           row_low;

    always_comb
    begin
        col_cur  = frame_start ? '0 : col_reg;
        row_cur  = frame_start ? '0 : row_reg;
        fill_cur = frame_start ? '0 : fill_reg;

        // At column zero the emitted pixel is the last column two rows up.
        col_nz  = (col_cur != '0);
        row_low = col_nz ? (row_cur == '0) : (row_cur < 12'd2);
        out_row = row_cur - (col_nz ? 12'd1 : 12'd2);
        out_col = col_nz ? ({1'b0, col_cur} - 12'd1) : (eff_width - 12'd1);

        item_next.px        = (operation == bts_pkg::OP_FLUSH) ? 1'b0 : pixel_in;
        item_next.fs        = frame_start;
        item_next.emit      = (fill_cur >= eff_width + 12'd1) && !row_low
                              && (out_row < eff_height);
        item_next.border    = (out_row == '0) || (out_row == eff_height - 12'd1)
                              || (out_col == '0) || (out_col >= eff_width - 12'd1);
        item_next.frame_end = (out_row == eff_height - 12'd1)
                              && (out_col == eff_width - 12'd1);
        item_next.row       = out_row[bts_pkg::POS_W-1:0];
        item_next.col       = out_col[bts_pkg::POS_W-1:0];
        item_next.addr      = col_cur[bts_pkg::ADDR_W-1:0];

        fill_next = (fill_cur < eff_width + 12'd1) ? fill_cur + 12'd1 : fill_cur;
        if ({1'b0, col_cur} + 12'd1 >= eff_width)
        begin
            col_next = '0;
            row_next = (row_cur < bts_pkg::ROW_LIMIT) ? row_cur + 12'd1 : row_cur;
        end
        else
        begin
            col_next = col_cur + 11'd1;
            row_next = row_cur;
        end

        s1_valid_next = advance ? accept : s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            fill_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                col_reg  <= col_next;
                row_reg  <= row_next;
                fill_reg <= fill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item_next;
        end
    end

    assign rd_addr  = item_next.addr;
    assign s1_valid = s1_valid_reg;
    assign s1_item  = s1_item_reg;

    // A frame start always leaves the scan one pixel into row zero.
    a_frame_start_restart: assert property (@(posedge clk) disable iff (!rst_n)
        accept && frame_start |=> col_reg == 11'd1 && row_reg == '0 && fill_reg == 12'd1)
        else $error("scan counters did not restart on frame start");

endmodule

// File: rtl/bts_line_buffer.sv
// Two one-bit line buffers held side by side in one memory, with a write-to-read bypass.
// Depends on bts_pkg for the buffer depth and address type.
module bts_line_buffer (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           rd_en,
    input  bts_pkg::addr_t rd_addr,
    input  logic           wr_en,
    input  bts_pkg::addr_t wr_addr,
    input  logic [1:0]     wr_data,
    output logic [1:0]     rd_data
);

    // Bit 1 is the upper line, bit 0 the middle line.
    logic [1:0] mem [bts_pkg::WIDTH_CAP];
    logic [1:0] mem_q_reg;
    logic [1:0] byp_data_reg;
    logic       byp_reg, byp_next;

    // A read that meets a write to the same entry takes the data being written.
    assign byp_next = rd_en ? (wr_en && (wr_addr == rd_addr)) : byp_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg    <= mem[rd_addr];
            byp_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
        end
    end

    assign rd_data = byp_reg ? byp_data_reg : mem_q_reg;

    // Read data must not move while no new read is issued.
    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !rd_en && !(wr_en && byp_reg) |=> $stable(rd_data))
        else $error("line buffer read data changed without a read");

endmodule

// File: rtl/bts_window_eval.sv
// 3x3 window register, the thinning decision on the window center and the result register.
// Depends on bts_pkg for item_t, position types and the neighbor count bounds.
module bts_window_eval (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  logic           s1_valid,
    input  bts_pkg::item_t s1_item,
    input  logic           top_bit,
    input  logic           mid_bit,
    input  logic           pass_select,
    output logic           out_valid,
    output logic           pixel_out,
    output bts_pkg::pos_t  out_row,
    output bts_pkg::pos_t  out_col,
    output logic           frame_end
);

    logic [8:0]    window_reg, window_next;
    logic [8:0]    window_base;
    logic          out_valid_reg, out_valid_next;
    logic          pixel_reg, pixel_next;
    bts_pkg::pos_t row_reg;
    bts_pkg::pos_t col_reg;
    logic          frame_end_reg;
    logic          step;

    // Returns 0 when the center pixel is to be cleared by this sub-pass.
    function automatic logic thin_keep(input logic [8:0] w, input logic sel);
        logic [7:0] ring;
        logic [3:0] nb_count;
        logic [3:0] rise_count;
        logic       c1, c2;
        ring = {w[0], w[3], w[6], w[7], w[8], w[5], w[2], w[1]};
        nb_count   = '0;
        rise_count = '0;
        for (int i = 0; i < 8; i++)
        begin
            nb_count = nb_count + {3'd0, ring[i]};
            rise_count = rise_count + {3'd0, (!ring[i] && ring[(i + 1) % 8])};
        end
        if (sel == bts_pkg::PASS_FIRST)
        begin
            c1 = ring[0] & ring[2] & ring[4];
            c2 = ring[2] & ring[4] & ring[6];
        end
        else
        begin
            c1 = ring[0] & ring[2] & ring[6];
            c2 = ring[0] & ring[4] & ring[6];
        end
        thin_keep = !((rise_count == 4'd1) && (nb_count >= bts_pkg::NB_COUNT_MIN)
                      && (nb_count <= bts_pkg::NB_COUNT_MAX) && !c1 && !c2);
    endfunction

    assign step = advance && s1_valid;

    always_comb
    begin
        window_base = s1_item.fs ? '0 : window_reg;
        // Each row shifts one column toward the oldest and takes the new column.
        window_next = {s1_item.px, window_base[8:7],
                       mid_bit,    window_base[5:4],
                       top_bit,    window_base[2:1]};
        if (s1_item.border || !window_next[4])
        begin
            pixel_next = window_next[4];
        end
        else
        begin
            pixel_next = thin_keep(window_next, pass_select);
        end
        out_valid_next = advance ? (s1_valid && s1_item.emit) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (step)
            begin
                window_reg <= window_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pixel_reg     <= pixel_next;
            row_reg       <= s1_item.row;
            col_reg       <= s1_item.col;
            frame_end_reg <= s1_item.frame_end;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pixel_reg;
    assign out_row   = row_reg;
    assign out_col   = col_reg;
    assign frame_end = frame_end_reg;

    a_emit_lands: assert property (@(posedge clk) disable iff (!rst_n)
        step && s1_item.emit |=> out_valid_reg)
        else $error("emitted pixel did not reach the result register");

    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(window_reg))
        else $error("window moved without a request in the stage");

endmodule
